/* hdl/tsc_pkg.sv */
// Shared types, codes and classification helpers for the token splitter
package tsc_pkg;

   // Token class codes on the result channel
   localparam logic [2:0] CLS_EOL  = 3'd0;
   localparam logic [2:0] CLS_STR  = 3'd1;
   localparam logic [2:0] CLS_SYM  = 3'd2;
   localparam logic [2:0] CLS_BOOL = 3'd3;
   localparam logic [2:0] CLS_INT  = 3'd4;
   localparam logic [2:0] CLS_FLT  = 3'd5;

   // Keyword match positions: 1..4 follow "true", 5..9 follow "false"
   localparam logic [3:0] BM_START = 4'd0;
   localparam logic [3:0] BM_T     = 4'd1;
   localparam logic [3:0] BM_TR    = 4'd2;
   localparam logic [3:0] BM_TRU   = 4'd3;
   localparam logic [3:0] BM_TRUE  = 4'd4;
   localparam logic [3:0] BM_F     = 4'd5;
   localparam logic [3:0] BM_FA    = 4'd6;
   localparam logic [3:0] BM_FAL   = 4'd7;
   localparam logic [3:0] BM_FALS  = 4'd8;
   localparam logic [3:0] BM_FALSE = 4'd9;
   localparam logic [3:0] BM_DEAD  = 4'd15;

   // Number prefix recognizer positions
   localparam logic [3:0] FP_START = 4'd0;
   localparam logic [3:0] FP_SIGN  = 4'd1;
   localparam logic [3:0] FP_DOT   = 4'd2;
   localparam logic [3:0] FP_I     = 4'd3;
   localparam logic [3:0] FP_IN    = 4'd4;
   localparam logic [3:0] FP_N     = 4'd5;
   localparam logic [3:0] FP_NA    = 4'd6;
   localparam logic [3:0] FP_OK    = 4'd7;
   localparam logic [3:0] FP_DEAD  = 4'd15;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_WORD = 2'd1,
      MODE_STR  = 2'd2
   } scan_mode_type;

   typedef struct packed {
      logic [7:0] token_char;
      logic       char_present;
      logic       token_done;
      logic [2:0] token_class;
      logic       run_last;
   } result_type;

   // One request's worth of results: one or two
   typedef struct packed {
      logic       two;
      result_type res0;
      result_type res1;
   } entry_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_bracket(input logic [7:0] c);
      return (c == "{") || (c == "}") || (c == "[") || (c == "]") ||
             (c == "(") || (c == ")");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   // Advance the true/false matcher by one byte
   function automatic logic [3:0] feed_bool(input logic [3:0] b, input logic [7:0] c);
      logic [3:0] n;
      n = BM_DEAD;
      case (b)
         BM_START: n = (c == "t") ? BM_T : ((c == "f") ? BM_F : BM_DEAD);
         BM_T:     n = (c == "r") ? BM_TR : BM_DEAD;
         BM_TR:    n = (c == "u") ? BM_TRU : BM_DEAD;
         BM_TRU:   n = (c == "e") ? BM_TRUE : BM_DEAD;
         BM_F:     n = (c == "a") ? BM_FA : BM_DEAD;
         BM_FA:    n = (c == "l") ? BM_FAL : BM_DEAD;
         BM_FAL:   n = (c == "s") ? BM_FALS : BM_DEAD;
         BM_FALS:  n = (c == "e") ? BM_FALSE : BM_DEAD;
         default:  n = BM_DEAD;
      endcase
      return n;
   endfunction

   // Advance the number prefix recognizer by one byte
   function automatic logic [3:0] feed_float(input logic [3:0] f, input logic [7:0] c);
      logic [7:0] l;
      logic [3:0] n;
      l = to_lower(c);
      n = FP_DEAD;
      case (f)
         FP_START, FP_SIGN: begin
            if (is_digit(c))
               n = FP_OK;
            else if (c == ".")
               n = FP_DOT;
            else if (l == "i")
               n = FP_I;
            else if (l == "n")
               n = FP_N;
            else if (f == FP_START && (c == "+" || c == "-"))
               n = FP_SIGN;
            else
               n = FP_DEAD;
         end
         FP_DOT:  n = is_digit(c) ? FP_OK : FP_DEAD;
         FP_I:    n = (l == "n") ? FP_IN : FP_DEAD;
         FP_IN:   n = (l == "f") ? FP_OK : FP_DEAD;
         FP_N:    n = (l == "a") ? FP_NA : FP_DEAD;
         FP_NA:   n = (l == "n") ? FP_OK : FP_DEAD;
         FP_OK:   n = FP_OK;
         default: n = FP_DEAD;
      endcase
      return n;
   endfunction

   function automatic logic [2:0] word_class(input logic [3:0] b, input logic digits,
                                             input logic [3:0] f);
      logic [2:0] cls;
      if (b == BM_TRUE || b == BM_FALSE)
         cls = CLS_BOOL;
      else if (digits)
         cls = CLS_INT;
      else if (f == FP_OK)
         cls = CLS_FLT;
      else
         cls = CLS_SYM;
      return cls;
   endfunction

   function automatic result_type char_result(input logic [7:0] c);
      result_type r;
      r.token_char   = c;
      r.char_present = 1'b1;
      r.token_done   = 1'b0;
      r.token_class  = CLS_EOL;
      r.run_last     = 1'b0;
      return r;
   endfunction

   function automatic result_type marker_result(input logic [2:0] cls);
      result_type r;
      r.token_char   = 8'd0;
      r.char_present = 1'b0;
      r.token_done   = 1'b1;
      r.token_class  = cls;
      r.run_last     = 1'b0;
      return r;
   endfunction

   function automatic result_type bracket_result(input logic [7:0] c);
      result_type r;
      r.token_char   = c;
      r.char_present = 1'b1;
      r.token_done   = 1'b1;
      r.token_class  = CLS_SYM;
      r.run_last     = 1'b0;
      return r;
   endfunction

endpackage

/* hdl/tsc_front.sv */
// Front end: scans bytes, tracks word class and builds result entries
module tsc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           text_byte,
   input  logic                 end_of_text,
   output logic                 entry_push,
   output tsc_pkg::entry_type   entry
);
   import tsc_pkg::*;

   scan_mode_type mode_ff, mode_in;
   logic [3:0]    bool_ff, bool_in;
   logic          digits_ff, digits_in;
   logic [3:0]    float_ff, float_in;

   logic [3:0]    bool_feed_word, bool_feed_new;
   logic [3:0]    float_feed_word, float_feed_new;
   logic [2:0]    cur_class;
   logic          term;

   assign bool_feed_word  = feed_bool(bool_ff, text_byte);
   assign float_feed_word = feed_float(float_ff, text_byte);
   assign bool_feed_new   = feed_bool(BM_START, text_byte);
   assign float_feed_new  = feed_float(FP_START, text_byte);
   assign cur_class       = word_class(bool_ff, digits_ff, float_ff);
   assign term            = is_space(text_byte) || is_bracket(text_byte);

   // Next scan and class state
   always_comb begin
      mode_in   = mode_ff;
      bool_in   = bool_ff;
      digits_in = digits_ff;
      float_in  = float_ff;
      if (accept) begin
         if (end_of_text) begin
            mode_in   = MODE_IDLE;
            bool_in   = BM_START;
            digits_in = 1'b1;
            float_in  = FP_START;
         end else begin
            case (mode_ff)
               MODE_STR: begin
                  if (text_byte == "\"")
                     mode_in = MODE_IDLE;
               end
               MODE_WORD: begin
                  if (term) begin
                     mode_in   = MODE_IDLE;
                     bool_in   = BM_START;
                     digits_in = 1'b1;
                     float_in  = FP_START;
                  end else begin
                     bool_in   = bool_feed_word;
                     digits_in = digits_ff & is_digit(text_byte);
                     float_in  = float_feed_word;
                  end
               end
               default: begin
                  mode_in = MODE_IDLE;
                  if (is_space(text_byte) || is_bracket(text_byte)) begin
                     mode_in = MODE_IDLE;
                  end else if (text_byte == "\"") begin
                     mode_in = MODE_STR;
                  end else begin
                     mode_in   = MODE_WORD;
                     bool_in   = bool_feed_new;
                     digits_in = is_digit(text_byte);
                     float_in  = float_feed_new;
                  end
               end
            endcase
         end
      end
   end

   // Build the result entry for this request
   always_comb begin
      entry_push = 1'b0;
      entry.two  = 1'b0;
      entry.res0 = marker_result(CLS_EOL);
      entry.res1 = marker_result(CLS_EOL);
      if (end_of_text) begin
         entry_push = 1'b1;
         case (mode_ff)
            MODE_WORD: begin
               entry.two  = 1'b1;
               entry.res0 = marker_result(cur_class);
            end
            MODE_STR: begin
               entry.two  = 1'b1;
               entry.res0 = marker_result(CLS_STR);
            end
            default: begin
               entry.two = 1'b0;
            end
         endcase
      end else begin
         case (mode_ff)
            MODE_STR: begin
               entry_push = 1'b1;
               if (text_byte == "\"")
                  entry.res0 = marker_result(CLS_STR);
               else
                  entry.res0 = char_result(text_byte);
            end
            MODE_WORD: begin
               entry_push = 1'b1;
               if (term) begin
                  entry.res0 = marker_result(cur_class);
                  entry.two  = is_bracket(text_byte);
                  entry.res1 = bracket_result(text_byte);
               end else begin
                  entry.res0 = char_result(text_byte);
               end
            end
            default: begin
               if (is_bracket(text_byte)) begin
                  entry_push = 1'b1;
                  entry.res0 = bracket_result(text_byte);
               end else if (!is_space(text_byte) && text_byte != "\"") begin
                  entry_push = 1'b1;
                  entry.res0 = char_result(text_byte);
               end
            end
         endcase
      end
      entry.res0.run_last = !entry.two;
      entry.res1.run_last = 1'b1;
      entry_push          = entry_push & accept;
   end

   // Hold scan state between requests
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         bool_ff   <= BM_START;
         digits_ff <= 1'b1;
         float_ff  <= FP_START;
      end else begin
         mode_ff   <= mode_in;
         bool_ff   <= bool_in;
         digits_ff <= digits_in;
         float_ff  <= float_in;
      end
   end

endmodule

/* hdl/tsc_queue.sv */
// Small entry queue decoupling the front end from the result stage
module tsc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tsc_pkg::entry_type   wdata,
   input  logic                 pop,
   output tsc_pkg::entry_type   rdata,
   output logic                 empty,
   output logic                 full
);
   import tsc_pkg::*;

   entry_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]       wptr_ff, wptr_in;
   logic [QUEUE_AW-1:0]       rptr_ff, rptr_in;
   logic [QUEUE_AW:0]         count_ff, count_in;
   logic                      do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push)
         slot_ff[wptr_ff] <= wdata;
   end

endmodule

/* hdl/tsc_back.sv */
// Back end: splits entries into single results and holds the output register
module tsc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  tsc_pkg::entry_type   entry,
   input  logic                 entry_valid,
   output logic                 entry_pop,
   input  logic                 out_pop,
   output logic                 out_empty,
   output tsc_pkg::result_type  out_result
);
   import tsc_pkg::*;

   logic       valid_ff, valid_in;
   logic       phase_ff, phase_in;
   result_type data_ff, data_in;
   logic       load;

   // Load when the output register is free or being drained
   assign load      = entry_valid && (!valid_ff || out_pop);
   assign entry_pop = load && (!entry.two || phase_ff);
   assign out_empty = !valid_ff;
   assign out_result = data_ff;

   always_comb begin
      data_in  = data_ff;
      phase_in = phase_ff;
      valid_in = valid_ff;
      if (load) begin
         data_in  = phase_ff ? entry.res1 : entry.res0;
         phase_in = entry.two && !phase_ff;
         valid_in = 1'b1;
      end else if (out_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

/* hdl/token_splitter_classifier.sv */
// A request accepted by the scanner is written to the entry queue, then moved into the output register.
// Throughput: one request per cycle while req_full is low; a request that yields two results holds the result
// stage while it hands out both, and req_full rises once the four-entry queue behind the scanner fills.
// Whitespace between tokens and opening quotes yield no result and take no queue slot.
// Reset is synchronous and active high: it clears scan state, the queue and the output.
module token_splitter_classifier (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_text,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_token_char,
   output logic       rsp_char_present,
   output logic       rsp_token_done,
   output logic [2:0] rsp_token_class,
   output logic       rsp_run_last
);
   import tsc_pkg::*;

   logic       accept;
   logic       entry_push;
   entry_type  wr_entry, rd_entry;
   logic       q_empty, q_full, q_pop;
   result_type result;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;

   tsc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .entry_push  (entry_push),
      .entry       (wr_entry)
   );

   tsc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (entry_push),
      .wdata (wr_entry),
      .pop   (q_pop),
      .rdata (rd_entry),
      .empty (q_empty),
      .full  (q_full)
   );

   tsc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry       (rd_entry),
      .entry_valid (!q_empty),
      .entry_pop   (q_pop),
      .out_pop     (rsp_pop),
      .out_empty   (rsp_empty),
      .out_result  (result)
   );

   assign rsp_token_char   = result.token_char;
   assign rsp_char_present = result.char_present;
   assign rsp_token_done   = result.token_done;
   assign rsp_token_class  = result.token_class;
   assign rsp_run_last     = result.run_last;

endmodule

/* hdl/tsc_checker.sv */
// Port-level checks for the token splitter, bound to the top level
module tsc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_token_char,
   input logic       rsp_char_present,
   input logic       rsp_token_done,
   input logic [2:0] rsp_token_class,
   input logic       rsp_run_last
);
   import tsc_pkg::*;

   // Hold a waiting result until it is taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_token_char) &&
         $stable(rsp_token_done) && $stable(rsp_token_class) && $stable(rsp_run_last)))
      else $error("waiting result changed before pop");

   // Content byte without close carries no class
   a_char: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_token_done) |-> (rsp_char_present && rsp_token_class == CLS_EOL))
      else $error("open result without content byte or with class");

   // Marker without content carries a zero byte
   a_marker: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_char_present) |-> (rsp_token_done && rsp_token_char == 8'd0))
      else $error("result without content byte is not a clean marker");

   // Class stays within the defined codes
   a_class: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_token_done) |-> (rsp_token_class <= CLS_FLT))
      else $error("undefined token class");

   // Come out of reset empty and ready
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> (rsp_empty && !req_full))
      else $error("not empty after reset");

endmodule

bind token_splitter_classifier tsc_checker u_tsc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_token_char   (rsp_token_char),
   .rsp_char_present (rsp_char_present),
   .rsp_token_done   (rsp_token_done),
   .rsp_token_class  (rsp_token_class),
   .rsp_run_last     (rsp_run_last)
);

/* tb/tb_top.sv */
// Self-checking testbench for the token splitter: byte stream in, token pieces out
`timescale 1ns / 100ps

module tb_top;
   import tsc_pkg::*;

   localparam int CYCLE_LIMIT = 250000;
   localparam int HOLD_CYCLES = 400;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [7:0] req_text_byte;
   logic       req_end_of_text;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [7:0] rsp_token_char;
   logic       rsp_char_present;
   logic       rsp_token_done;
   logic [2:0] rsp_token_class;
   logic       rsp_run_last;

   int send_idle_pct;
   int recv_idle_pct;
   bit hold_req;
   int cycles;

   token_splitter_classifier u_top (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_token_char  (rsp_token_char),
      .rsp_char_present(rsp_char_present),
      .rsp_token_done  (rsp_token_done),
      .rsp_token_class (rsp_token_class),
      .rsp_run_last    (rsp_run_last)
   );

   always #5 clock = ~clock;

   function automatic bit blank_byte(input logic [7:0] b);
      return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic bit bracket_byte(input logic [7:0] b);
      return b == "{" || b == "}" || b == "[" || b == "]" || b == "(" || b == ")";
   endfunction

   // Tracks scanner state and holds the token pieces still owed by the block
   class token_tracker;
      scan_mode_type mode;
      logic [3:0]    kw_pos;
      logic          only_digits;
      logic [3:0]    num_pos;
      result_type    owed_pieces[$];
      int            bad_pieces;

      function new();
         mode = MODE_IDLE;
         restart_word();
         bad_pieces = 0;
      endfunction

      function void restart_word();
         kw_pos      = BM_START;
         only_digits = 1'b1;
         num_pos     = FP_START;
      endfunction

      function result_type piece(logic [7:0] ch, logic present, logic done,
                                 logic [2:0] cls);
         result_type p;
         p.token_char   = ch;
         p.char_present = present;
         p.token_done   = done;
         p.token_class  = cls;
         p.run_last     = 1'b0;
         return p;
      endfunction

      function logic [2:0] class_of_word();
         if (kw_pos == BM_TRUE || kw_pos == BM_FALSE)
            return CLS_BOOL;
         if (only_digits)
            return CLS_INT;
         if (num_pos == FP_OK)
            return CLS_FLT;
         return CLS_SYM;
      endfunction

      // Advance keyword, digit and number-prefix trackers by one word byte
      function void absorb(logic [7:0] b);
         string      yes_word;
         string      no_word;
         logic [7:0] lc;
         bit         digit;
         yes_word = "true";
         no_word  = "false";
         digit    = b >= "0" && b <= "9";
         lc       = (b >= "A" && b <= "Z") ? b + 8'd32 : b;

         if (kw_pos == BM_START)
            kw_pos = (b == "t") ? BM_T : (b == "f") ? BM_F : BM_DEAD;
         else if (kw_pos >= BM_T && kw_pos <= BM_TRU)
            kw_pos = (b == yes_word[kw_pos]) ? kw_pos + 4'd1 : BM_DEAD;
         else if (kw_pos >= BM_F && kw_pos <= BM_FALS)
            kw_pos = (b == no_word[kw_pos - 4]) ? kw_pos + 4'd1 : BM_DEAD;
         else
            kw_pos = BM_DEAD;

         if (!digit)
            only_digits = 1'b0;

         case (num_pos)
            FP_START, FP_SIGN: begin
               if (digit)
                  num_pos = FP_OK;
               else if (b == ".")
                  num_pos = FP_DOT;
               else if (lc == "i")
                  num_pos = FP_I;
               else if (lc == "n")
                  num_pos = FP_N;
               else if (num_pos == FP_START && (b == "+" || b == "-"))
                  num_pos = FP_SIGN;
               else
                  num_pos = FP_DEAD;
            end
            FP_DOT:  num_pos = digit ? FP_OK : FP_DEAD;
            FP_I:    num_pos = (lc == "n") ? FP_IN : FP_DEAD;
            FP_IN:   num_pos = (lc == "f") ? FP_OK : FP_DEAD;
            FP_N:    num_pos = (lc == "a") ? FP_NA : FP_DEAD;
            FP_NA:   num_pos = (lc == "n") ? FP_OK : FP_DEAD;
            FP_OK:   num_pos = FP_OK;
            default: num_pos = FP_DEAD;
         endcase
      endfunction

      // Work out the pieces one accepted request owes
      function void note_request(logic [7:0] b, logic eot);
         result_type got[$];
         if (eot) begin
            if (mode == MODE_WORD)
               got.push_back(piece(8'h00, 1'b0, 1'b1, class_of_word()));
            else if (mode == MODE_STR)
               got.push_back(piece(8'h00, 1'b0, 1'b1, CLS_STR));
            got.push_back(piece(8'h00, 1'b0, 1'b1, CLS_EOL));
            mode = MODE_IDLE;
            restart_word();
         end else if (mode == MODE_STR) begin
            if (b == "\"") begin
               got.push_back(piece(8'h00, 1'b0, 1'b1, CLS_STR));
               mode = MODE_IDLE;
            end else begin
               got.push_back(piece(b, 1'b1, 1'b0, CLS_EOL));
            end
         end else if (mode == MODE_WORD) begin
            if (blank_byte(b) || bracket_byte(b)) begin
               got.push_back(piece(8'h00, 1'b0, 1'b1, class_of_word()));
               restart_word();
               mode = MODE_IDLE;
               if (bracket_byte(b))
                  got.push_back(piece(b, 1'b1, 1'b1, CLS_SYM));
            end else begin
               absorb(b);
               got.push_back(piece(b, 1'b1, 1'b0, CLS_EOL));
            end
         end else begin
            mode = MODE_IDLE;
            if (blank_byte(b)) begin
               // drop whitespace between tokens
            end else if (b == "\"") begin
               mode = MODE_STR;
            end else if (bracket_byte(b)) begin
               got.push_back(piece(b, 1'b1, 1'b1, CLS_SYM));
            end else begin
               restart_word();
               absorb(b);
               mode = MODE_WORD;
               got.push_back(piece(b, 1'b1, 1'b0, CLS_EOL));
            end
         end
         if (got.size() > 0)
            got[got.size() - 1].run_last = 1'b1;
         foreach (got[i])
            owed_pieces.push_back(got[i]);
      endfunction

      // Compare one popped result against the oldest owed piece
      function void check_result(result_type seen);
         result_type want;
         if (owed_pieces.size() == 0) begin
            bad_pieces++;
            if (bad_pieces <= 10)
               $display("unexpected result: char %h present %b done %b class %0d last %b",
                        seen.token_char, seen.char_present, seen.token_done,
                        seen.token_class, seen.run_last);
            return;
         end
         want = owed_pieces.pop_front();
         if (seen.token_char !== want.token_char || seen.char_present !== want.char_present ||
             seen.token_done !== want.token_done || seen.token_class !== want.token_class ||
             seen.run_last !== want.run_last) begin
            bad_pieces++;
            if (bad_pieces <= 10)
               $display("mismatch: expected char %h present %b done %b class %0d last %b, %s",
                        want.token_char, want.char_present, want.token_done,
                        want.token_class, want.run_last,
                        $sformatf("got char %h present %b done %b class %0d last %b",
                                  seen.token_char, seen.char_present, seen.token_done,
                                  seen.token_class, seen.run_last));
         end
      endfunction
   endclass

   token_tracker tracker;

   // Offer one request, idling at random first, and hold it until accepted
   task automatic send_request(input logic [7:0] b, input logic eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push        <= 1'b1;
      req_text_byte   <= b;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      tracker.note_request(b, eot);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_request(s[i], 1'b0);
   endtask

   // Hold off new requests until every owed piece has come out
   task automatic drain_pieces();
      req_push <= 1'b0;
      while (tracker.owed_pieces.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [7:0] word_byte();
      logic [7:0] b;
      do begin
         if ($urandom_range(7) == 0)
            b = 8'($urandom_range(255));
         else
            b = 8'($urandom_range(8'h21, 8'h7E));
      end while (blank_byte(b) || bracket_byte(b));
      return b;
   endfunction

   function automatic logic [7:0] blank_pick();
      return $urandom_range(1) ? 8'h20 : 8'h09 + 8'($urandom_range(4));
   endfunction

   function automatic logic [7:0] bracket_pick();
      string br;
      br = "{}[]()";
      return br[$urandom_range(5)];
   endfunction

   // Mostly well-formed tokens with random content, some noise and broken tokens
   task automatic send_random_text(input int n_items);
      logic [8:0] seg[$];
      int         sent;
      int         kind;
      string      kw;
      logic [7:0] b;
      sent = 0;
      while (sent < n_items) begin
         seg = {};
         kind = $urandom_range(15);
         case (kind)
            0, 1, 2: begin
               if ($urandom_range(1))
                  kw = "true";
               else
                  kw = "false";
               for (int i = 0; i < kw.len(); i++)
                  seg.push_back({1'b0, kw[i]});
               // break the keyword now and then
               case ($urandom_range(5))
                  0: void'(seg.pop_back());
                  1: seg.push_back({1'b0, word_byte()});
                  2: seg[$urandom_range(seg.size() - 1)] = {1'b0, word_byte()};
                  default: ;
               endcase
            end
            3, 4: begin
               repeat ($urandom_range(1, 6))
                  seg.push_back({1'b0, 8'h30 + 8'($urandom_range(9))});
            end
            5, 6, 7: begin
               if ($urandom_range(2) == 0)
                  seg.push_back({1'b0, $urandom_range(1) ? 8'h2B : 8'h2D});
               case ($urandom_range(4))
                  0: begin
                     repeat ($urandom_range(1, 3))
                        seg.push_back({1'b0, 8'h30 + 8'($urandom_range(9))});
                     seg.push_back({1'b0, 8'h2E});
                  end
                  1: begin
                     seg.push_back({1'b0, 8'h2E});
                     seg.push_back({1'b0, 8'h30 + 8'($urandom_range(9))});
                  end
                  2, 3: begin
                     if ($urandom_range(1))
                        kw = "inf";
                     else
                        kw = "nan";
                     for (int i = 0; i < kw.len(); i++) begin
                        b = kw[i];
                        if ($urandom_range(1))
                           b = b - 8'd32;
                        seg.push_back({1'b0, b});
                     end
                  end
                  default: begin
                     seg.push_back({1'b0, $urandom_range(1) ? 8'h2E : 8'h2D});
                     seg.push_back({1'b0, word_byte()});
                  end
               endcase
               repeat ($urandom_range(3))
                  seg.push_back({1'b0, word_byte()});
            end
            8, 9: begin
               do
                  b = word_byte();
               while (b == "\"");
               seg.push_back({1'b0, b});
               repeat ($urandom_range(5))
                  seg.push_back({1'b0, word_byte()});
            end
            10, 11: begin
               seg.push_back({1'b0, 8'h22});
               repeat ($urandom_range(6)) begin
                  do
                     b = 8'($urandom_range(255));
                  while (b == "\"");
                  seg.push_back({1'b0, b});
               end
               // leave a string open into a flush now and then
               if ($urandom_range(5) != 0)
                  seg.push_back({1'b0, 8'h22});
               else
                  seg.push_back({1'b1, 8'($urandom_range(255))});
            end
            12, 13: seg.push_back({1'b0, bracket_pick()});
            14:     seg.push_back({1'b1, 8'($urandom_range(255))});
            default: begin
               repeat ($urandom_range(1, 3))
                  seg.push_back({($urandom_range(15) == 0), 8'($urandom_range(255))});
            end
         endcase

         // close words with whitespace, a bracket or a flush
         if (kind <= 9) begin
            case ($urandom_range(9))
               0:       seg.push_back({1'b1, 8'($urandom_range(255))});
               1, 2:    seg.push_back({1'b0, bracket_pick()});
               default: seg.push_back({1'b0, blank_pick()});
            endcase
         end else if ($urandom_range(1)) begin
            seg.push_back({1'b0, blank_pick()});
         end

         foreach (seg[i]) begin
            send_request(seg[i][7:0], seg[i][8]);
            sent++;
         end
      end
   endtask

   // Pop results, check them, and stall at random or for a long hold
   initial begin
      result_type seen;
      int         hold_left;
      hold_left = 0;
      do
         @(posedge clock);
      while (reset);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            seen.token_char   = rsp_token_char;
            seen.char_present = rsp_char_present;
            seen.token_done   = rsp_token_done;
            seen.token_class  = rsp_token_class;
            seen.run_last     = rsp_run_last;
            tracker.check_result(seen);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Bound the run
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Main sequence
   initial begin
      reset           = 1'b1;
      req_push        = 1'b0;
      req_text_byte   = 8'h00;
      req_end_of_text = 1'b0;
      rsp_pop         = 1'b0;
      hold_req        = 1'b0;
      send_idle_pct   = 0;
      recv_idle_pct   = 0;
      tracker         = new();
      repeat (12)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: keyword, number prefix, bracket ends, strings, flushes
      send_text("true ");
      send_text("-.5}");
      send_text("\"\"");
      send_request(8'h22, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h00, 1'b1);
      send_text("4\"2");
      send_request(8'hA5, 1'b1);
      send_request(8'h00, 1'b1);
      send_text("NaN(");
      send_request(8'h00, 1'b0);
      send_request(8'h09, 1'b0);
      drain_pieces();

      // random: three idling phases, long receiver hold in the last
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 7;
               recv_idle_pct = 78;
            end
            1: begin
               send_idle_pct = 78;
               recv_idle_pct = 7;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               hold_req      = 1'b1;
            end
         endcase
         send_random_text(560);
         drain_pieces();
      end

      repeat (20)
         @(posedge clock);
      if (tracker.bad_pieces == 0 && tracker.owed_pieces.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/tsc_pkg.sv
hdl/tsc_front.sv
hdl/tsc_queue.sv
hdl/tsc_back.sv
hdl/token_splitter_classifier.sv
hdl/tsc_checker.sv
tb/tb_top.sv
